// ----- rtl/core/gwm_pkg.sv -----
// ----------------------------------------------------------------------------
// gwm_pkg - shared types and constants of the glob wildcard matcher
// Opcodes, the classified command that travels from front to back, and the
// sizes of the pattern store and the command queue.
// ----------------------------------------------------------------------------
package gwm_pkg;

    // Pattern store depth in bytes (1 .. 256)
    localparam int MAX_PATTERN = 32;
    // Pattern length counter: holds 0 .. MAX_PATTERN
    localparam int LEN_W       = $clog2(MAX_PATTERN + 1);

    // Command queue depth, a power of two
    localparam int Q_DEPTH     = 4;
    localparam int Q_AW        = $clog2(Q_DEPTH);

    localparam logic [7:0] CH_ANY  = 8'h3F;  // '?'
    localparam logic [7:0] CH_STAR = 8'h2A;  // '*'

    typedef enum logic [1:0] {
        OP_PATTERN     = 2'd0,
        OP_TEXT        = 2'd1,
        OP_END_PATTERN = 2'd2,
        OP_END_TEXT    = 2'd3
    } t_op;

    typedef struct packed {
        t_op        op;
        logic [7:0] data_byte;
        logic       is_star;
        logic       is_any;
    } t_cmd;

endpackage

// ----- rtl/core/gwm_front.sv -----
// ----------------------------------------------------------------------------
// gwm_front - input stage of the glob wildcard matcher
// Registers each input transfer, tags wildcard bytes and hands the command
// on to the queue.
// ----------------------------------------------------------------------------
module gwm_front import gwm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_ready,
    input  logic [1:0] i_op,
    input  logic [7:0] i_data,
    output logic       o_push,
    output t_cmd       o_cmd,
    input  logic       i_q_full
);

    logic r_valid;
    t_cmd r_cmd;
    t_cmd n_cmd;

    assign o_ready = !r_valid || !i_q_full;
    assign o_push  = r_valid && !i_q_full;
    assign o_cmd   = r_cmd;

    always_comb begin
        n_cmd.op        = t_op'(i_op);
        n_cmd.data_byte = i_data;
        n_cmd.is_star   = (i_data == CH_STAR);
        n_cmd.is_any    = (i_data == CH_ANY);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_valid && o_ready) begin
            r_valid <= 1'b1;
        end else if (o_push) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && o_ready) begin
            r_cmd <= n_cmd;
        end
    end

endmodule

// ----- rtl/core/gwm_queue.sv -----
// ----------------------------------------------------------------------------
// gwm_queue - command queue between front and back
// Small register FIFO; lets the input side keep running while the back
// waits on the result port.
// ----------------------------------------------------------------------------
module gwm_queue import gwm_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    output logic o_full,
    input  logic i_pop,
    output logic o_valid,
    output t_cmd o_cmd
);

    t_cmd            r_mem [Q_DEPTH];
    logic [Q_AW-1:0] r_wr;
    logic [Q_AW-1:0] r_rd;
    logic [Q_AW:0]   r_cnt;

    assign o_full  = (r_cnt == (Q_AW + 1)'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_cmd   = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (!i_push && i_pop) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

endmodule

// ----- rtl/core/gwm_back.sv -----
// ----------------------------------------------------------------------------
// gwm_back - execution stage of the glob wildcard matcher
// Holds the pattern and the live-position vector, advances it per text byte
// and drives the result register.
// ----------------------------------------------------------------------------
module gwm_back import gwm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_q_valid,
    input  t_cmd       i_cmd,
    output logic       o_pop,
    output logic       o_out_valid,
    input  logic       i_out_ready,
    output logic       o_matched,
    output logic       o_overflow
);

    // Pattern payload, masked by r_active
    logic [7:0]             r_store [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] r_star;
    logic [MAX_PATTERN-1:0] r_any;

    logic [MAX_PATTERN-1:0] r_active;
    logic [LEN_W-1:0]       r_len;
    logic [MAX_PATTERN:0]   r_rearm;   // start vector: position 0 plus leading stars
    logic [MAX_PATTERN:0]   r_live;
    logic                   r_ovf;
    logic                   r_closed;

    logic                   r_out_valid;
    logic                   r_matched;
    logic                   r_overflow;

    logic [LEN_W-1:0]       base_len;
    logic [MAX_PATTERN-1:0] base_active;
    logic [MAX_PATTERN:0]   base_rearm;
    logic                   base_ovf;
    logic                   has_room;
    logic [MAX_PATTERN-1:0] wr_sel;

    logic [MAX_PATTERN-1:0] n_active;
    logic [LEN_W-1:0]       n_len;
    logic [MAX_PATTERN:0]   n_rearm;
    logic                   n_ovf;

    logic [MAX_PATTERN:0]   live0;
    logic [MAX_PATTERN:0]   seed;
    logic [MAX_PATTERN:0]   s_ext;
    logic [MAX_PATTERN:0]   gen;
    logic [MAX_PATTERN:0]   sum;
    logic [MAX_PATTERN:0]   stepped;
    logic                   is_end_text;
    logic                   hit_now;

    assign is_end_text = (i_cmd.op == OP_END_TEXT);
    assign o_pop       = i_q_valid && (!is_end_text || !r_out_valid || i_out_ready);

    // Pattern load: a byte after a closed pattern starts a new one
    always_comb begin
        base_len    = r_closed ? '0 : r_len;
        base_active = r_closed ? '0 : r_active;
        base_ovf    = r_closed ? 1'b0 : r_ovf;
        base_rearm  = r_closed ? (MAX_PATTERN + 1)'(1) : r_rearm;
        has_room    = (base_len < LEN_W'(MAX_PATTERN));
        for (int i = 0; i < MAX_PATTERN; i++) begin
            wr_sel[i] = has_room && (base_len == LEN_W'(i));
        end
        n_active = base_active | wr_sel;
        n_len    = has_room ? base_len + 1'b1 : base_len;
        n_ovf    = base_ovf || !has_room;
        n_rearm  = base_rearm;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            n_rearm[i+1] = n_rearm[i+1] | (wr_sel[i] & i_cmd.is_star & base_rearm[i]);
        end
    end

    // Text step: an open pattern is closed first, so start from the rearm vector
    always_comb begin
        live0 = r_closed ? r_live : r_rearm;
        seed  = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (r_active[i] && live0[i]) begin
                if (r_star[i]) begin
                    seed[i]   = 1'b1;
                    seed[i+1] = 1'b1;
                end else if (r_any[i] || (r_store[i] == i_cmd.data_byte)) begin
                    seed[i+1] = 1'b1;
                end
            end
        end
        // Star closure as a carry chain: stars propagate, live stars generate
        s_ext   = {1'b0, r_star & r_active};
        gen     = seed & s_ext;
        sum     = s_ext + gen;
        stepped = seed | (sum ^ s_ext ^ gen);
    end

    assign hit_now = live0[r_len] && !r_ovf;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= '0;
            r_len    <= '0;
            r_rearm  <= (MAX_PATTERN + 1)'(1);
            r_live   <= (MAX_PATTERN + 1)'(1);
            r_ovf    <= 1'b0;
            r_closed <= 1'b1;
        end else if (o_pop) begin
            unique case (i_cmd.op) inside
                OP_PATTERN: begin
                    r_closed <= 1'b0;
                    r_active <= n_active;
                    r_len    <= n_len;
                    r_rearm  <= n_rearm;
                    r_ovf    <= n_ovf;
                end
                OP_TEXT: begin
                    r_closed <= 1'b1;
                    r_live   <= stepped;
                end
                OP_END_PATTERN, OP_END_TEXT: begin
                    r_closed <= 1'b1;
                    r_live   <= r_rearm;
                end
                default: begin
                    r_closed <= r_closed;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (o_pop && (i_cmd.op == OP_PATTERN) && wr_sel[i]) begin
                r_store[i] <= i_cmd.data_byte;
                r_star[i]  <= i_cmd.is_star;
                r_any[i]   <= i_cmd.is_any;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (o_pop && is_end_text) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && is_end_text) begin
            r_matched  <= hit_now;
            r_overflow <= r_ovf;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_matched   = r_matched;
    assign o_overflow  = r_overflow;

endmodule

// ----- rtl/core/glob_wildcard_matcher.sv -----
// ----------------------------------------------------------------------------
// glob_wildcard_matcher - streaming '?' / '*' pattern matcher
// Loads a pattern byte by byte, then matches text bytes against it with a
// vector of live pattern positions; one result per end of text.
// ----------------------------------------------------------------------------
//
//  Channel   Dir  tdata                          tuser
//  s_axis    in   [7:0] byte_value               [1:0] opcode (pattern, text,
//                                                      end pattern, end text)
//  m_axis    out  [0] matched, [1] pattern_overflow, [7:2] zero    -
//
//  Cycles: one item per cycle sustained, every opcode, while the result port
//  does not stall. The live vector is updated for all pattern positions at
//  once: one byte-compare bank plus a single (MAX_PATTERN+1)-bit add that
//  ripples star closure as a carry. An input transfer passes the input
//  register, the queue and the back stage on its way into the result register.
//  Reset: synchronous, active low; no clearing pass, the pattern store is
//  masked by its valid vector and is usable the cycle after reset.
//  Stalls: a four-entry queue parts front and back; the back waits only on
//  end of text while the result register is full and not taken.
// ----------------------------------------------------------------------------
module glob_wildcard_matcher import gwm_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] byte_value
    input  logic [1:0] s_axis_tuser,   // [1:0] opcode
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] matched, [1] pattern_overflow, [7:2] zero
);

    logic push;
    t_cmd push_cmd;
    logic q_full;
    logic q_valid;
    t_cmd q_cmd;
    logic pop;
    logic matched;
    logic overflow;

    // Front: register and classify each transfer
    gwm_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (s_axis_tvalid),
        .o_ready  (s_axis_tready),
        .i_op     (s_axis_tuser),
        .i_data   (s_axis_tdata),
        .o_push   (push),
        .o_cmd    (push_cmd),
        .i_q_full (q_full)
    );

    // Queue: absorb back-side stalls
    gwm_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .o_full  (q_full),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_cmd   (q_cmd)
    );

    // Back: pattern store, live vector and result register
    gwm_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_q_valid   (q_valid),
        .i_cmd       (q_cmd),
        .o_pop       (pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_matched   (matched),
        .o_overflow  (overflow)
    );

    assign m_axis_tdata = {6'b0, overflow, matched};

endmodule

// ----- rtl/core/gwm_checker.sv -----
// ----------------------------------------------------------------------------
// gwm_checker - port-level checks for the glob wildcard matcher
// Watches the stream ports over time; attached to the top level by bind.
// ----------------------------------------------------------------------------
module gwm_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       s_axis_tready,
    input  logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    input  logic [7:0] m_axis_tdata
);

    // Hold a stalled result until it is taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result dropped or changed while stalled");

    // Overflow forces no match
    a_ovf_no_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
        else $error("match reported on overflowed pattern");

    // Padding bits stay zero
    a_pad_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[7:2] == 6'd0))
        else $error("nonzero padding in result");

    // Reset empties the result register and opens the input
    a_reset_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    a_reset_in: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

endmodule

bind glob_wildcard_matcher gwm_checker u_gwm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ----- tb/sv/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top - self-checking bench for the glob wildcard matcher
// Streams patterns and texts into the matcher with random gaps on the input
// and random back-pressure on the output. A live-position tracker mirrors the
// matcher and queues one verdict per end of text. Each result transfer is
// compared against the oldest queued verdict.
// ----------------------------------------------------------------------------
module tb_top;
    import gwm_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // Cycles without any transfer on either side before the run is abandoned
    localparam int STALL_LIMIT = 2000;
    // Cycles to keep watching the output once every verdict has arrived
    localparam int DRAIN_CYCLES = 16;

    typedef struct packed {
        logic matched;
        logic overflow;
    } t_verdict;

    // ------------------------------------------------------------------------
    // Clock, reset and block under test
    // ------------------------------------------------------------------------
    logic       i_clk = 1'b0;
    logic       i_rst_n = 1'b0;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata = '0;     // [7:0] byte_value
    logic [1:0] s_axis_tuser = '0;     // [1:0] opcode
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;          // [0] matched, [1] pattern_overflow, [7:2] zero

    always begin
        #5ns i_clk = 1'b1;
        #5ns i_clk = 1'b0;
    end

    glob_wildcard_matcher u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    // ------------------------------------------------------------------------
    // Shared bench state
    // ------------------------------------------------------------------------
    t_verdict verdict_q[$];    // verdicts still owed by the matcher
    int       err_cnt = 0;
    int       sent_cmds = 0;
    int       idle_cycles = 0;
    int       rx_hold = 0;
    bit       calm = 1'b0;     // when set, neither side inserts gaps

    // Own copy of the matcher state: the loaded pattern, its length, the
    // overflow flag, whether the pattern is closed, and the live positions.
    logic [7:0]             pat_mem [MAX_PATTERN];
    logic [LEN_W-1:0]       pat_len = '0;
    logic                   pat_ovf = 1'b0;
    logic                   pat_done = 1'b1;
    logic [MAX_PATTERN:0]   live_vec = (MAX_PATTERN + 1)'(1);

    // ------------------------------------------------------------------------
    // Live-position tracker
    // ------------------------------------------------------------------------

    // Close stars forward: a live star also makes the next position live.
    // Walk upward so a run of stars propagates in one pass.
    function automatic void spread_stars();
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i < pat_len && live_vec[i] && pat_mem[i] == CH_STAR)
                live_vec[i+1] = 1'b1;
        end
    endfunction

    function automatic void restart_live();
        live_vec = (MAX_PATTERN + 1)'(1);
        spread_stars();
    endfunction

    function automatic void close_pattern();
        pat_done = 1'b1;
        restart_live();
    endfunction

    function automatic void consume_text(logic [7:0] c);
        logic [MAX_PATTERN:0] nxt;
        nxt = '0;
        for (int i = 0; i < MAX_PATTERN; i++) begin
            if (i < pat_len && live_vec[i]) begin
                if (pat_mem[i] == CH_STAR) begin
                    nxt[i]   = 1'b1;
                    nxt[i+1] = 1'b1;
                end else if (pat_mem[i] == CH_ANY || pat_mem[i] == c) begin
                    nxt[i+1] = 1'b1;
                end
            end
        end
        live_vec = nxt;
        spread_stars();
    endfunction

    // Apply one accepted command; queue a verdict on end of text.
    function automatic void step_matcher(t_op op, logic [7:0] b);
        t_verdict v;
        case (op)
            OP_PATTERN: begin
                // a pattern byte after a closed pattern starts a new one
                if (pat_done) begin
                    pat_done = 1'b0;
                    pat_len  = '0;
                    pat_ovf  = 1'b0;
                end
                if (pat_len < MAX_PATTERN) begin
                    pat_mem[pat_len] = b;
                    pat_len++;
                end else begin
                    pat_ovf = 1'b1;
                end
            end
            OP_END_PATTERN: close_pattern();
            OP_TEXT: begin
                if (!pat_done) close_pattern();
                consume_text(b);
            end
            default: begin
                if (!pat_done) close_pattern();
                v.matched  = live_vec[pat_len] && !pat_ovf;
                v.overflow = pat_ovf;
                verdict_q.push_back(v);
                restart_live();
            end
        endcase
    endfunction

    // ------------------------------------------------------------------------
    // Gap lengths: mostly none or short, now and then long
    // ------------------------------------------------------------------------
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 50) return 0;
        if (r < 90) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ------------------------------------------------------------------------
    // Input side: one command per call. Valid stays high across back-to-back
    // transfers; drop it only when a gap is inserted.
    // ------------------------------------------------------------------------
    task automatic drive_cmd(t_op op, logic [7:0] b);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tuser  <= op;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        step_matcher(op, b);
        sent_cmds++;
    endtask

    // ------------------------------------------------------------------------
    // Output side: random back-pressure, with calm stretches always ready
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (rx_hold > 0) begin
            rx_hold--;
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
            if (!calm && $urandom_range(0, 3) == 0) rx_hold = gap_len();
        end
    end

    // Compare every result transfer against the oldest queued verdict
    always @(posedge i_clk) begin
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $error("unexpected result transfer, tdata 0x%02h", m_axis_tdata);
                err_cnt++;
            end else begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want.matched) begin
                    $error("matched: expected %0b, got %0b", want.matched, m_axis_tdata[0]);
                    err_cnt++;
                end
                if (m_axis_tdata[1] !== want.overflow) begin
                    $error("pattern_overflow: expected %0b, got %0b",
                           want.overflow, m_axis_tdata[1]);
                    err_cnt++;
                end
                if (m_axis_tdata[7:2] !== 6'd0) begin
                    $error("reserved: expected 0x00, got 0x%02h", m_axis_tdata[7:2]);
                    err_cnt++;
                end
            end
        end
    end

    // Watchdog: abandon the run when nothing moves for too long
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------------
    function automatic logic [7:0] pick_pat_byte();
        int r;
        r = $urandom_range(0, 9);
        if (r < 5) return 8'h61 + 8'($urandom_range(0, 2));   // 'a' .. 'c'
        if (r < 7) return CH_ANY;
        if (r < 9) return CH_STAR;
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] pick_text_byte();
        if ($urandom_range(0, 9) < 8) return 8'h61 + 8'($urandom_range(0, 2));
        return 8'($urandom_range(0, 255));
    endfunction

    // One pattern followed by a few texts shaped after it. A bent text has
    // bytes dropped or injected so that it may miss.
    task automatic run_episode();
        logic [7:0] pat[$];
        int         plen;
        bit         bent;
        plen = ($urandom_range(0, 19) == 0) ? $urandom_range(30, MAX_PATTERN + 4)
                                            : $urandom_range(1, 8);
        repeat (plen) begin
            pat.push_back(pick_pat_byte());
            drive_cmd(OP_PATTERN, pat[$]);
        end
        // now and then leave the close to the first text byte
        if ($urandom_range(0, 4) != 0) drive_cmd(OP_END_PATTERN, 8'($urandom_range(0, 255)));
        repeat ($urandom_range(1, 4)) begin
            bent = 1'($urandom_range(0, 1));
            foreach (pat[i]) begin
                if (bent && $urandom_range(0, 9) == 0) continue;
                if (bent && $urandom_range(0, 9) == 0) drive_cmd(OP_TEXT, pick_text_byte());
                if (pat[i] == CH_STAR)
                    repeat ($urandom_range(0, 3)) drive_cmd(OP_TEXT, pick_text_byte());
                else if (pat[i] == CH_ANY)
                    drive_cmd(OP_TEXT, 8'($urandom_range(0, 255)));
                else
                    drive_cmd(OP_TEXT, pat[i]);
            end
            // re-arm in the middle of a text once in a while
            if ($urandom_range(0, 19) == 0)
                drive_cmd(OP_END_PATTERN, 8'($urandom_range(0, 255)));
            drive_cmd(OP_END_TEXT, 8'($urandom_range(0, 255)));
        end
    endtask

    // Unstructured commands: any opcode, any byte
    task automatic run_noise();
        repeat ($urandom_range(1, 6))
            drive_cmd(t_op'(2'($urandom_range(0, 3))), 8'($urandom_range(0, 255)));
    endtask

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------

    // Right after reset the pattern is empty: only the empty text matches.
    task automatic test_empty_pattern();
        drive_cmd(OP_END_TEXT, 8'hFF);
        drive_cmd(OP_TEXT, 8'h00);
        drive_cmd(OP_END_TEXT, 8'h00);
    endtask

    // '?' takes exactly one byte, '*' any run including none; byte extremes.
    task automatic test_wildcards();
        drive_cmd(OP_PATTERN, 8'h61);
        drive_cmd(OP_PATTERN, CH_ANY);
        drive_cmd(OP_PATTERN, CH_STAR);
        drive_cmd(OP_PATTERN, 8'hFF);
        drive_cmd(OP_END_PATTERN, 8'hFF);
        drive_cmd(OP_TEXT, 8'h61);        // star takes an empty run
        drive_cmd(OP_TEXT, 8'h00);
        drive_cmd(OP_TEXT, 8'hFF);
        drive_cmd(OP_END_TEXT, 8'h00);
        drive_cmd(OP_TEXT, 8'h61);        // star swallows a literal star
        drive_cmd(OP_TEXT, 8'h62);
        drive_cmd(OP_TEXT, CH_STAR);
        drive_cmd(OP_TEXT, 8'hFF);
        drive_cmd(OP_END_TEXT, 8'hFF);
        drive_cmd(OP_TEXT, 8'h61);        // '?' cannot match nothing
        drive_cmd(OP_TEXT, 8'hFF);
        drive_cmd(OP_END_TEXT, 8'h00);
    endtask

    // Text closes an open pattern; end of pattern on a closed one re-arms.
    task automatic test_implicit_close_and_rearm();
        drive_cmd(OP_PATTERN, 8'h78);
        drive_cmd(OP_TEXT, 8'h78);
        drive_cmd(OP_END_PATTERN, 8'h00);
        drive_cmd(OP_TEXT, 8'h78);
        drive_cmd(OP_END_TEXT, 8'h00);
    endtask

    // One byte past the store sets overflow and forces a miss even for an
    // all-star pattern; the next pattern clears the flag.
    task automatic test_overflow();
        repeat (MAX_PATTERN + 1) drive_cmd(OP_PATTERN, CH_STAR);
        drive_cmd(OP_END_TEXT, 8'h00);
        drive_cmd(OP_PATTERN, 8'h7A);
        drive_cmd(OP_TEXT, 8'h7A);
        drive_cmd(OP_END_TEXT, 8'h00);
    endtask

    // Mostly well-formed episodes with random content, some noise; switch
    // the gaps off for whole episodes now and then.
    task automatic test_random_streams();
        int stop_at;
        stop_at = sent_cmds + 380;
        while (sent_cmds < stop_at) begin
            calm = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 7) == 0) run_noise();
            else run_episode();
        end
        calm = 1'b0;
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_empty_pattern();
        test_wildcards();
        test_implicit_close_and_rearm();
        test_overflow();
        test_random_streams();

        // stop sending, wait out every owed verdict, then watch for strays
        s_axis_tvalid <= 1'b0;
        while (verdict_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (err_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/gwm_pkg.sv
rtl/core/gwm_front.sv
rtl/core/gwm_queue.sv
rtl/core/gwm_back.sv
rtl/core/glob_wildcard_matcher.sv
rtl/core/gwm_checker.sv
tb/sv/tb_top.sv
